### rtl/swss_pkg.sv
// Package with the shared types and constants of the sliding-window statistics block.
package swss_pkg;

  // Width of the threshold register and of the reported fill count.
  localparam int unsigned CFG_W  = 6;
  localparam int unsigned FILL_W = 6;

  // Threshold value after reset.
  localparam logic [CFG_W-1:0] MIN_VALID_RESET = 6'd10;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PASS1,
    ST_DIV_MEAN,
    ST_PASS2,
    ST_DIV_VAR,
    ST_SQRT,
    ST_FINISH
  } seq_state_t;

endpackage

### rtl/sliding_window_sample_stats.sv
// Sliding-window sample statistics: ring window, sequencer and shared subtract unit.
//
// Usage: each word on the input channel (in_valid / in_stall) is one converter
// sample. It is written into a ring window of the last WINDOW_DEPTH samples and
// gives exactly one word on the result channel (out_valid / out_stall): the
// fill count, a valid flag, and the truncated mean, minimum, maximum and
// integer standard deviation over the filled entries. Until the fill count
// reaches cfg_min_valid_count the statistics read as zero.
// The threshold is written through cfg_valid / cfg_ready; the user must write it only
// while the block is idle, which the block itself does not enforce. One sample is handled
// at a time. A sample below the threshold goes straight from the check to the finish
// state. Otherwise the sequencer makes two passes over the n filled entries through the
// single window read port, two restoring divisions through the shared subtractor and a
// square root through the same subtractor, one root digit per cycle.
// in_stall is high while a sample is in work. A finished word waits in the
// output register while the receiver stalls; the next sample is already
// accepted meanwhile, and its result waits until the register is free.
// Reset clears the fill count, the write position, the threshold (to 10) and
// the output valid flag; window contents are not cleared.
module sliding_window_sample_stats #(
  parameter int unsigned WINDOW_DEPTH = 50,
  parameter int unsigned SAMPLE_BITS  = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [swss_pkg::CFG_W-1:0]    cfg_min_valid_count,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [SAMPLE_BITS-1:0]        in_sample_value,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_stats_valid,
  output logic [swss_pkg::FILL_W-1:0]   out_fill_count,
  output logic [SAMPLE_BITS-1:0]        out_mean_value,
  output logic [SAMPLE_BITS-2:0]        out_std_deviation,
  output logic [SAMPLE_BITS-1:0]        out_min_value,
  output logic [SAMPLE_BITS-1:0]        out_max_value
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CW    = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUMW  = SB + CW;
  localparam int unsigned DW    = 2 * SB + CW;
  localparam int unsigned SW    = $clog2(DW + 1);
  localparam int unsigned REMW  = (CW > SB) ? CW : SB;
  localparam int unsigned SUBW  = (CW + 1 > SB + 2) ? CW + 1 : SB + 2;
  localparam int unsigned CMPW  = (CW > swss_pkg::CFG_W) ? CW : swss_pkg::CFG_W;

  // Window memory.
  logic [SB-1:0]          mem [WINDOW_DEPTH];
  logic [SB-1:0]          rd_data_r;

  // Control and datapath registers.
  swss_pkg::seq_state_t   state_r, state_nxt;
  logic [AW-1:0]          wp_r, wp_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [swss_pkg::CFG_W-1:0] min_valid_r;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic [2*SB-1:0]        prod_r;
  logic                   prod_vld_r, prod_vld_nxt;
  logic [SUMW-1:0]        sum_r, sum_nxt;
  logic [DW-1:0]          sq_r, sq_nxt;
  logic [SB-1:0]          lo_r, lo_nxt;
  logic [SB-1:0]          hi_r, hi_nxt;
  logic [SB-1:0]          mean_r, mean_nxt;
  logic [DW-1:0]          quo_r, quo_nxt;
  logic [REMW-1:0]        rem_r, rem_nxt;
  logic [SB-1:0]          root_r, root_nxt;
  logic [SW-1:0]          step_r, step_nxt;
  logic                   valid_r, valid_nxt;

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_sv_r;
  logic [CW-1:0]          out_cnt_r;
  logic [SB-1:0]          out_mean_r, out_min_r, out_max_r;
  logic [SB-2:0]          out_std_r;
  logic                   out_load;

  logic                   in_accept;
  logic                   issue;
  logic [SB-1:0]          abs_diff;

  // Shared subtract-and-compare unit.
  logic [SUBW-1:0]        alu_a, alu_b;
  logic [SUBW:0]          alu_diff;
  logic                   alu_ge;

  assign in_accept = in_valid && (state_r == swss_pkg::ST_IDLE);
  assign in_stall  = (state_r != swss_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // Read issue during either pass: one entry per cycle up to the fill count.
  assign issue = ((state_r == swss_pkg::ST_PASS1) || (state_r == swss_pkg::ST_PASS2)) &&
                 (idx_r < cnt_r);

  // Window write at accept, registered read during the passes.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mem[wp_r] <= in_sample_value;
    end
    if (issue) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
    end
  end

  // Absolute deviation and its square, registered before accumulation.
  assign abs_diff = (rd_data_r >= mean_r) ? (rd_data_r - mean_r) : (mean_r - rd_data_r);

  always_ff @(posedge clk) begin
    if (rd_vld_r && (state_r == swss_pkg::ST_PASS2)) begin
      prod_r <= abs_diff * abs_diff;
    end
  end

  // Operand selection for the shared subtractor: a division step or a root digit.
  always_comb begin
    if (state_r == swss_pkg::ST_SQRT) begin
      alu_a = SUBW'({rem_r[SB-1:0], quo_r[2*SB-1 -: 2]});
      alu_b = SUBW'({root_r, 2'b01});
    end else begin
      alu_a = SUBW'({rem_r[CW-1:0], quo_r[DW-1]});
      alu_b = SUBW'(cnt_r);
    end
  end

  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_ge   = !alu_diff[SUBW];

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    rd_vld_nxt    = issue;
    prod_vld_nxt  = rd_vld_r && (state_r == swss_pkg::ST_PASS2);
    sum_nxt       = sum_r;
    sq_nxt        = sq_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mean_nxt      = mean_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    step_nxt      = step_r;
    valid_nxt     = valid_r;
    out_load      = 1'b0;

    if (issue) begin
      idx_nxt = idx_r + 1'b1;
    end

    case (state_r)
      swss_pkg::ST_IDLE: begin
        if (in_accept) begin
          wp_nxt = (wp_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_r + 1'b1;
          if (cnt_r != CW'(WINDOW_DEPTH)) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          state_nxt = swss_pkg::ST_CHECK;
        end
      end

      // Compare the fill count against the threshold and prepare the first pass, or zero the statistics below it.
      swss_pkg::ST_CHECK: begin
        valid_nxt = (CMPW'(cnt_r) >= CMPW'(min_valid_r));
        idx_nxt   = '0;
        sum_nxt   = '0;
        lo_nxt    = '1;
        hi_nxt    = '0;
        if (CMPW'(cnt_r) >= CMPW'(min_valid_r)) begin
          state_nxt = swss_pkg::ST_PASS1;
        end else begin
          mean_nxt  = '0;
          root_nxt  = '0;
          lo_nxt    = '0;
          state_nxt = swss_pkg::ST_FINISH;
        end
      end

      // First pass: sum, minimum and maximum.
      swss_pkg::ST_PASS1: begin
        if (rd_vld_r) begin
          sum_nxt = sum_r + SUMW'(rd_data_r);
          if (rd_data_r < lo_r) begin
            lo_nxt = rd_data_r;
          end
          if (rd_data_r > hi_r) begin
            hi_nxt = rd_data_r;
          end
        end
        if ((idx_r == cnt_r) && !rd_vld_r) begin
          quo_nxt   = DW'(sum_r);
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = swss_pkg::ST_DIV_MEAN;
        end
      end

      // Restoring division of the sum by the fill count.
      swss_pkg::ST_DIV_MEAN: begin
        quo_nxt  = {quo_r[DW-2:0], alu_ge};
        rem_nxt  = alu_ge ? REMW'(alu_diff[SUBW-1:0]) : REMW'(alu_a);
        step_nxt = step_r + 1'b1;
        if (step_r == SW'(DW - 1)) begin
          mean_nxt  = quo_nxt[SB-1:0];
          idx_nxt   = '0;
          sq_nxt    = '0;
          state_nxt = swss_pkg::ST_PASS2;
        end
      end

      // Second pass: sum of squared deviations from the truncated mean.
      swss_pkg::ST_PASS2: begin
        if (prod_vld_r) begin
          sq_nxt = sq_r + DW'(prod_r);
        end
        if ((idx_r == cnt_r) && !rd_vld_r && !prod_vld_r) begin
          quo_nxt   = sq_r;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = swss_pkg::ST_DIV_VAR;
        end
      end

      // Restoring division of the squared sum by the fill count.
      swss_pkg::ST_DIV_VAR: begin
        quo_nxt  = {quo_r[DW-2:0], alu_ge};
        rem_nxt  = alu_ge ? REMW'(alu_diff[SUBW-1:0]) : REMW'(alu_a);
        step_nxt = step_r + 1'b1;
        if (step_r == SW'(DW - 1)) begin
          rem_nxt   = '0;
          root_nxt  = '0;
          step_nxt  = '0;
          state_nxt = swss_pkg::ST_SQRT;
        end
      end

      // Integer square root, one result digit per cycle.
      swss_pkg::ST_SQRT: begin
        quo_nxt  = quo_r << 2;
        rem_nxt  = alu_ge ? REMW'(alu_diff[SUBW-1:0]) : REMW'(alu_a);
        root_nxt = {root_r[SB-2:0], alu_ge};
        step_nxt = step_r + 1'b1;
        if (step_r == SW'(SB - 1)) begin
          state_nxt = swss_pkg::ST_FINISH;
        end
      end

      // Hand the word to the output register once it is free.
      swss_pkg::ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = swss_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = swss_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, cleared when the word is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      cnt_r       <= '0;
      min_valid_r <= swss_pkg::MIN_VALID_RESET;
      rd_vld_r    <= 1'b0;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      prod_vld_r  <= prod_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        min_valid_r <= cfg_min_valid_count;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    sum_r   <= sum_nxt;
    sq_r    <= sq_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mean_r  <= mean_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    step_r  <= step_nxt;
    valid_r <= valid_nxt;
    if (out_load) begin
      out_sv_r   <= valid_r;
      out_cnt_r  <= cnt_r;
      out_mean_r <= mean_r;
      out_std_r  <= root_r[SB-2:0];
      out_min_r  <= lo_r;
      out_max_r  <= hi_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_stats_valid   = out_sv_r;
  assign out_fill_count    = swss_pkg::FILL_W'(out_cnt_r);
  assign out_mean_value    = out_mean_r;
  assign out_std_deviation = out_std_r;
  assign out_min_value     = out_min_r;
  assign out_max_value     = out_max_r;

`ifndef SYNTHESIS
  // The fill count never passes the window depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(WINDOW_DEPTH))
    else $error("fill count above window depth");

  // The write position stays inside the window.
  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(wp_r) < WINDOW_DEPTH)
    else $error("write position outside window");

  // A new result word only appears after the sequencer has finished a sample.
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == swss_pkg::ST_FINISH))
    else $error("result word without a finished sample");

  // A word below the threshold carries zero statistics.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_sv_r) |-> ((out_mean_r == '0) && (out_std_r == '0) &&
                                    (out_min_r == '0) && (out_max_r == '0)))
    else $error("statistics not zero below threshold");
`endif

endmodule

### sim/swss_stats_checker.sv
// Checker that predicts and compares every result word of the sliding-window statistics block.
`timescale 1ns / 100ps

module swss_stats_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [swss_pkg::CFG_W-1:0]   cfg_min_valid_count,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [11:0]                  in_sample_value,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         out_stats_valid,
  input  logic [swss_pkg::FILL_W-1:0]  out_fill_count,
  input  logic [11:0]                  out_mean_value,
  input  logic [10:0]                  out_std_deviation,
  input  logic [11:0]                  out_min_value,
  input  logic [11:0]                  out_max_value,
  output int                           fail_count,
  output int                           words_pending
);

  localparam int unsigned WIN = 50;

  typedef struct packed {
    logic                        stats_valid;
    logic [swss_pkg::FILL_W-1:0] fill_count;
    logic [11:0]                 mean_value;
    logic [10:0]                 std_deviation;
    logic [11:0]                 min_value;
    logic [11:0]                 max_value;
  } stats_word_t;

  // Shadow copy of the block state and its threshold register.
  logic [11:0]                win_copy [WIN];
  int unsigned                wr_pos;
  int unsigned                fill;
  logic [swss_pkg::CFG_W-1:0] min_count;

  stats_word_t expected_stats [$];

  // Push one sample into the shadow window and work out the word it gives.
  function automatic stats_word_t absorb_sample(input logic [11:0] sample);
    stats_word_t       r;
    longint unsigned   sum;
    longint unsigned   sq;
    longint unsigned   var_q;
    int unsigned       mean;
    int unsigned       dev;
    int unsigned       lo;
    int unsigned       hi;
    int unsigned       root;
    int unsigned       trial;
    int                i;
    int                b;
    win_copy[wr_pos] = sample;
    wr_pos = (wr_pos == WIN - 1) ? 0 : wr_pos + 1;
    if (fill < WIN) fill++;
    r = '0;
    r.fill_count = fill[swss_pkg::FILL_W-1:0];
    r.stats_valid = (fill >= min_count);
    if (r.stats_valid) begin
      sum = 0;
      lo = 4095;
      hi = 0;
      for (i = 0; i < fill; i++) begin
        sum += 64'(win_copy[i]);
        if (32'(win_copy[i]) < lo) lo = 32'(win_copy[i]);
        if (32'(win_copy[i]) > hi) hi = 32'(win_copy[i]);
      end
      mean = 32'(sum / fill);
      sq = 0;
      for (i = 0; i < fill; i++) begin
        dev = (32'(win_copy[i]) >= mean) ? 32'(win_copy[i]) - mean : mean - 32'(win_copy[i]);
        sq += longint'(dev) * dev;
      end
      var_q = sq / fill;
      // Integer square root, one result bit at a time from the top.
      root = 0;
      for (b = 11; b >= 0; b--) begin
        trial = root | (32'd1 << b);
        if (longint'(trial) * trial <= var_q) root = trial;
      end
      r.mean_value    = mean[11:0];
      r.std_deviation = root[10:0];
      r.min_value     = lo[11:0];
      r.max_value     = hi[11:0];
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [11:0] exp_v,
                             input logic [11:0] act_v, inout int errs);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errs++;
    end
  endtask

  // Watch the three channels at every edge.
  always @(posedge clk) begin : watch
    stats_word_t exp_w;
    int          errs;
    int          delta;
    errs = 0;
    delta = 0;
    if (!rst_n) begin
      wr_pos = 0;
      fill = 0;
      min_count = swss_pkg::MIN_VALID_RESET;
      expected_stats.delete();
      words_pending <= 0;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) min_count = cfg_min_valid_count;
      // Compare a delivered result word with the oldest expectation.
      if (out_valid && !out_stall) begin
        if (expected_stats.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual fill %0d mean %0d",
                   $time, out_fill_count, out_mean_value);
          errs++;
        end else begin
          exp_w = expected_stats.pop_front();
          delta--;
          check_field("stats_valid", 12'(exp_w.stats_valid), 12'(out_stats_valid), errs);
          check_field("fill_count", 12'(exp_w.fill_count), 12'(out_fill_count), errs);
          check_field("mean_value", exp_w.mean_value, out_mean_value, errs);
          check_field("std_deviation", 12'(exp_w.std_deviation), 12'(out_std_deviation),
                      errs);
          check_field("min_value", exp_w.min_value, out_min_value, errs);
          check_field("max_value", exp_w.max_value, out_max_value, errs);
        end
      end
      // An accepted sample word queues its prediction.
      if (in_valid && !in_stall) begin
        expected_stats.push_back(absorb_sample(in_sample_value));
        delta++;
      end
      words_pending <= words_pending + delta;
      fail_count <= fail_count + errs;
    end
  end

endmodule

### sim/tb_top.sv
// Top level of the testbench: clock, reset, stimulus, idling and the final verdict.
`timescale 1ns / 100ps

module tb_top;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [swss_pkg::CFG_W-1:0]    cfg_min_valid_count = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [11:0]                   in_sample_value = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_stats_valid;
  logic [swss_pkg::FILL_W-1:0]   out_fill_count;
  logic [11:0]                   out_mean_value;
  logic [10:0]                   out_std_deviation;
  logic [11:0]                   out_min_value;
  logic [11:0]                   out_max_value;

  int                  fail_count;
  int                  words_pending;
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_idle_pct = 0;

  // Extremes and bit patterns first, then a full-swing square wave.
  logic [11:0] directed_words [0:23] = '{
    12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h001, 12'h800, 12'h7FF, 12'hFFE,
    12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'hFFF,
    12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'hFFF
  };

  // Threshold per random phase: always valid, zero, depth, above depth, and others.
  logic [swss_pkg::CFG_W-1:0] phase_min [0:8] = '{
    6'd1, 6'd0, 6'd50, 6'd63, 6'd51, 6'd25, 6'd10, 6'd2, 6'd49
  };

  sliding_window_sample_stats uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_min_valid_count (cfg_min_valid_count),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample_value     (in_sample_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_stats_valid     (out_stats_valid),
    .out_fill_count      (out_fill_count),
    .out_mean_value      (out_mean_value),
    .out_std_deviation   (out_std_deviation),
    .out_min_value       (out_min_value),
    .out_max_value       (out_max_value)
  );

  swss_stats_checker checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_min_valid_count (cfg_min_valid_count),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample_value     (in_sample_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_stats_valid     (out_stats_valid),
    .out_fill_count      (out_fill_count),
    .out_mean_value      (out_mean_value),
    .out_std_deviation   (out_std_deviation),
    .out_min_value       (out_min_value),
    .out_max_value       (out_max_value),
    .fail_count          (fail_count),
    .words_pending       (words_pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Run limit far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // The receiver stalls at random with the current idle rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Offer one sample word, with random idle cycles ahead of it.
  task automatic send_sample(input logic [11:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold the sender until every result has come, then write the threshold.
  task automatic write_min_count(input logic [swss_pkg::CFG_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_min_valid_count <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned                phase;
    int unsigned                k;
    int unsigned                style;
    int unsigned                base;
    logic [11:0]                value;
    logic [swss_pkg::CFG_W-1:0] thr;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset threshold: not yet valid, then valid.
    send_idle_pct = 25;
    recv_idle_pct <= 56;
    for (k = 0; k < 24; k++) send_sample(directed_words[k]);

    for (phase = 0; phase < 9; phase++) begin
      thr = (phase == 5) ? swss_pkg::CFG_W'($urandom_range(0, 63)) : phase_min[phase];
      write_min_count(thr);
      if (phase < 3) begin
        send_idle_pct = 25;
        recv_idle_pct <= 56;
      end else if (phase < 6) begin
        send_idle_pct = 56;
        recv_idle_pct <= 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      // Sample styles change every window length to shape the spread.
      for (k = 0; k < 120; k++) begin
        if (k % 50 == 0) begin
          style = $urandom_range(0, 4);
          base = $urandom_range(0, 4095);
        end
        case (style)
          0: value = 12'($urandom_range(0, 4095));
          1: value = 12'((base % 4064) + $urandom_range(0, 31));
          2: value = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
          3: value = 12'(base);
          default: value = 12'(4095 - $urandom_range(0, 7));
        endcase
        send_sample(value);
      end
    end

    // Drain and give the verdict.
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
